// File: hdl/devf_pkg.sv
package devf_pkg;

   localparam int ROTOR_BITS_DEF = 14;
   localparam int LINK_BITS_DEF  = 12;

   localparam int GEAR_W  = 16;
   localparam int JOINT_W = 23;
   localparam int TURN_W  = 8;

   localparam logic [GEAR_W-1:0]  GEAR_RESET   = 16'd256;
   localparam logic [GEAR_W-1:0]  UNITY_GEAR   = 16'd256;
   localparam logic [GEAR_W-1:0]  DIRECT_LIMIT = 16'd268;
   localparam logic [JOINT_W-1:0] JOINT_MAX    = {JOINT_W{1'b1}};

endpackage

// File: hdl/devf_req_if.sv
interface devf_req_if
   import devf_pkg::*;
#(
   parameter int LINK_BITS  = LINK_BITS_DEF,
   parameter int ROTOR_BITS = ROTOR_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [LINK_BITS-1:0]  link_angle;
   logic [ROTOR_BITS-1:0] rotor_angle;

   modport source (output valid, output link_angle, output rotor_angle, input ready);
   modport sink   (input valid, input link_angle, input rotor_angle, output ready);
endinterface

// File: hdl/devf_rsp_if.sv
interface devf_rsp_if
   import devf_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [JOINT_W-1:0] joint_angle;
   logic [TURN_W-1:0]  turn_index;

   modport source (output valid, output joint_angle, output turn_index, input ready);
   modport sink   (input valid, input joint_angle, input turn_index, output ready);
endinterface

// File: hdl/dual_encoder_vernier_fusion_top.sv
// A result becomes valid once its transaction has passed stages s1 to s5, the divider
// stages and the output register, if the output is free.
// Throughput: one transaction per cycle while the skid register is empty; the quotient
// comes from JOINT_W divider stages that each resolve one bit, each holding another item.
// Reset (synchronous, active high) empties the pipeline and the output register and
// sets the gear ratio register to 256 (Q8.8 for 1.0, direct drive).
module dual_encoder_vernier_fusion_top
   import devf_pkg::*;
#(
   parameter int ROTOR_BITS = ROTOR_BITS_DEF,
   parameter int LINK_BITS  = LINK_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   devf_req_if.sink           req_chan,
   devf_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [GEAR_W-1:0]  csr_wr_data
);

   localparam int PROD_W = GEAR_W + LINK_BITS;
   localparam int NUM_W  = PROD_W + ROTOR_BITS + 1;
   localparam int MAG_W  = NUM_W - 1;
   localparam int SHIFT  = 8 + LINK_BITS + ROTOR_BITS;
   localparam int Q_W    = NUM_W - SHIFT;
   localparam int DIV_W  = TURN_W + ROTOR_BITS + GEAR_W;
   localparam int REM_W  = GEAR_W + 1;
   localparam logic [NUM_W-1:0]  HALF  = NUM_W'(1) << (SHIFT - 1);
   localparam logic [REM_W-1:0]  N_RND = REM_W'(128);

   // Configuration
   logic [GEAR_W-1:0] gear_ff;
   logic              direct;
   logic [GEAR_W-1:0] divisor;

   assign direct  = (gear_ff <= DIRECT_LIMIT);
   assign divisor = direct ? UNITY_GEAR : gear_ff;

   // Pipeline enable: everything moves unless the skid register is occupied.
   logic en;
   logic skid_v_ff;
   assign en = !skid_v_ff;
   assign req_chan.ready = en;

   // Front stages
   logic                  s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [LINK_BITS-1:0]  s1_link_ff;
   logic [ROTOR_BITS-1:0] s1_rotor_ff, s2_rotor_ff, s3_rotor_ff, s4_rotor_ff, s5_rotor_ff;
   logic [PROD_W-1:0]     s2_prod_ff, s2_prod_in;
   logic [NUM_W-1:0]      s3_num_ff, s3_num_in;
   logic [NUM_W-1:0]      pos_term, neg_term, abs_full, round_sum;
   logic [MAG_W-1:0]      s4_mag_ff, s4_mag_in;
   logic                  s4_neg_ff, s4_neg_in, s5_neg_ff;
   logic [Q_W-1:0]        s5_q_ff, s5_q_in;

   always_comb begin
      s2_prod_in = PROD_W'(gear_ff) * PROD_W'(s1_link_ff);
      pos_term   = {1'b0, s2_prod_ff, {ROTOR_BITS{1'b0}}};
      neg_term   = NUM_W'(s2_rotor_ff) << (8 + LINK_BITS);
      s3_num_in  = pos_term - neg_term;
      s4_neg_in  = s3_num_ff[NUM_W-1];
      abs_full   = s4_neg_in ? (NUM_W'(0) - s3_num_ff) : s3_num_ff;
      s4_mag_in  = abs_full[MAG_W-1:0];
      round_sum  = {1'b0, s4_mag_ff} + HALF;
      s5_q_in    = round_sum[NUM_W-1:SHIFT];
   end

   // Turn index reduction and divider setup. A negative index can only be -1,
   // and a positive one never exceeds round(N), so one correction suffices.
   logic [REM_W-1:0]  n_full;
   logic [Q_W-1:0]    n_turns;
   logic [Q_W-1:0]    k_red;
   logic [TURN_W-1:0] turn0_in;
   logic [DIV_W-1:0]  dividend;
   logic [REM_W-1:0]  top_ext;
   logic              sat0_in;
   logic [GEAR_W-1:0] rem0_in;

   always_comb begin
      n_full  = {1'b0, gear_ff} + N_RND;
      n_turns = n_full[GEAR_W:8];
      priority if (s5_neg_ff && (s5_q_ff != '0)) begin
         k_red = n_turns - s5_q_ff;
      end else if (s5_q_ff >= n_turns) begin
         k_red = s5_q_ff - n_turns;
      end else begin
         k_red = s5_q_ff;
      end
      turn0_in = direct ? '0 : k_red[TURN_W-1:0];
      // The rounding offset divisor/2 stays below 2^15, so it fills the low bits.
      dividend = {turn0_in, s5_rotor_ff, 1'b0, divisor[GEAR_W-1:1]};
      top_ext  = REM_W'(dividend[DIV_W-1:JOINT_W]);
      sat0_in  = (top_ext >= {1'b0, divisor});
      rem0_in  = sat0_in ? '0 : top_ext[GEAR_W-1:0];
   end

   // Divider stages: index 0 is loaded from the setup logic, each later index
   // holds one more quotient bit. qd shifts dividend bits out and quotient bits in.
   logic               dv_v_ff   [JOINT_W+1];
   logic [GEAR_W-1:0]  rem_ff    [JOINT_W+1];
   logic [GEAR_W-1:0]  rem_in    [JOINT_W+1];
   logic [JOINT_W-1:0] qd_ff     [JOINT_W+1];
   logic [JOINT_W-1:0] qd_in     [JOINT_W+1];
   logic               sat_ff    [JOINT_W+1];
   logic [TURN_W-1:0]  turn_ff   [JOINT_W+1];
   logic [REM_W-1:0]   trial     [JOINT_W];
   logic [REM_W-1:0]   diff      [JOINT_W];
   logic               take      [JOINT_W];

   always_comb begin
      rem_in[0] = rem0_in;
      qd_in[0]  = dividend[JOINT_W-1:0];
      for (int j = 0; j < JOINT_W; j++) begin
         trial[j]    = {rem_ff[j], qd_ff[j][JOINT_W-1]};
         diff[j]     = trial[j] - {1'b0, divisor};
         take[j]     = (trial[j] >= {1'b0, divisor});
         rem_in[j+1] = take[j] ? diff[j][GEAR_W-1:0] : trial[j][GEAR_W-1:0];
         qd_in[j+1]  = {qd_ff[j][JOINT_W-2:0], take[j]};
      end
   end

   // Output register with one skid entry.
   logic               out_v_ff, out_v_in, skid_v_in;
   logic [JOINT_W-1:0] out_joint_ff, out_joint_in, skid_joint_ff, skid_joint_in;
   logic [TURN_W-1:0]  out_turn_ff, out_turn_in, skid_turn_ff, skid_turn_in;
   logic               push, pop;
   logic [JOINT_W-1:0] push_joint;

   assign push       = en && dv_v_ff[JOINT_W];
   assign pop        = out_v_ff && rsp_chan.ready;
   assign push_joint = sat_ff[JOINT_W] ? JOINT_MAX : qd_ff[JOINT_W];

   always_comb begin
      out_v_in      = out_v_ff;
      out_joint_in  = out_joint_ff;
      out_turn_in   = out_turn_ff;
      skid_v_in     = skid_v_ff;
      skid_joint_in = skid_joint_ff;
      skid_turn_in  = skid_turn_ff;
      priority if (pop && skid_v_ff) begin
         out_joint_in = skid_joint_ff;
         out_turn_in  = skid_turn_ff;
         skid_v_in    = 1'b0;
      end else if (pop || !out_v_ff) begin
         out_v_in     = push;
         out_joint_in = push_joint;
         out_turn_in  = turn_ff[JOINT_W];
      end else if (push) begin
         skid_v_in     = 1'b1;
         skid_joint_in = push_joint;
         skid_turn_in  = turn_ff[JOINT_W];
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.joint_angle = out_joint_ff;
   assign rsp_chan.turn_index  = out_turn_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff   <= GEAR_RESET;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         s4_v_ff   <= 1'b0;
         s5_v_ff   <= 1'b0;
         for (int j = 0; j <= JOINT_W; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            gear_ff <= csr_wr_data;
         end
         if (en) begin
            s1_v_ff    <= req_chan.valid;
            s2_v_ff    <= s1_v_ff;
            s3_v_ff    <= s2_v_ff;
            s4_v_ff    <= s3_v_ff;
            s5_v_ff    <= s4_v_ff;
            dv_v_ff[0] <= s5_v_ff;
            for (int j = 0; j < JOINT_W; j++) begin
               dv_v_ff[j+1] <= dv_v_ff[j];
            end
         end
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_link_ff  <= req_chan.link_angle;
         s1_rotor_ff <= req_chan.rotor_angle;
         s2_prod_ff  <= s2_prod_in;
         s2_rotor_ff <= s1_rotor_ff;
         s3_num_ff   <= s3_num_in;
         s3_rotor_ff <= s2_rotor_ff;
         s4_mag_ff   <= s4_mag_in;
         s4_neg_ff   <= s4_neg_in;
         s4_rotor_ff <= s3_rotor_ff;
         s5_q_ff     <= s5_q_in;
         s5_neg_ff   <= s4_neg_ff;
         s5_rotor_ff <= s4_rotor_ff;
         sat_ff[0]   <= sat0_in;
         turn_ff[0]  <= turn0_in;
         for (int j = 0; j <= JOINT_W; j++) begin
            rem_ff[j] <= rem_in[j];
            qd_ff[j]  <= qd_in[j];
         end
         for (int j = 0; j < JOINT_W; j++) begin
            sat_ff[j+1]  <= sat_ff[j];
            turn_ff[j+1] <= turn_ff[j];
         end
      end
      out_joint_ff  <= out_joint_in;
      out_turn_ff   <= out_turn_in;
      skid_joint_ff <= skid_joint_in;
      skid_turn_ff  <= skid_turn_in;
   end

endmodule

// File: hdl/devf_checker.sv
module devf_checker
   import devf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [JOINT_W-1:0] joint_angle,
   input logic [TURN_W-1:0]  turn_index,
   input logic               csr_wr_en,
   input logic [GEAR_W-1:0]  csr_wr_data
);

   // Shadow copy of the gear ratio as seen on the configuration port.
   logic [GEAR_W-1:0] gear_ff;
   logic [GEAR_W:0]   n_full;
   logic [TURN_W:0]   n_turns;
   logic              direct;

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff <= GEAR_RESET;
      end else if (csr_wr_en) begin
         gear_ff <= csr_wr_data;
      end
   end

   assign n_full  = {1'b0, gear_ff} + (GEAR_W + 1)'(128);
   assign n_turns = n_full[GEAR_W:8];
   assign direct  = (gear_ff <= DIRECT_LIMIT);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(joint_angle) && $stable(turn_index))
      else $error("stalled result changed or vanished");

   // Input is only held off while a finished result waits at the output.
   a_backpressure_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input blocked with no pending result");

   a_direct_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && direct |-> turn_index == '0)
      else $error("nonzero turn index in direct drive");

   a_turn_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !direct |-> {1'b0, turn_index} < n_turns)
      else $error("turn index not reduced below the rounded gear ratio");

endmodule

bind dual_encoder_vernier_fusion_top devf_checker u_devf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .joint_angle (rsp_chan.joint_angle),
   .turn_index  (rsp_chan.turn_index),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
